// ===== hdl/wbc_pkg.sv =====
package wbc_pkg;

   localparam int CFG_W = 13;
   localparam int DIV_W = 20;
   localparam int DIV_CNT_W = 5;
   localparam int DSR_W = 13;

   // item kinds on the input channel
   localparam logic [2:0] KIND_PAL_WRITE = 3'd0;
   localparam logic [2:0] KIND_TOP_SAMPLE = 3'd1;
   localparam logic [2:0] KIND_BOT_SAMPLE = 3'd2;
   localparam logic [2:0] KIND_LATCH = 3'd3;
   localparam logic [2:0] KIND_PIXEL = 3'd4;

   // operations queued for the back end
   localparam logic [2:0] OP_PAL_WRITE = 3'd0;
   localparam logic [2:0] OP_TOP_SAMPLE = 3'd1;
   localparam logic [2:0] OP_BOT_SAMPLE = 3'd2;
   localparam logic [2:0] OP_LATCH = 3'd3;
   localparam logic [2:0] OP_PASS = 3'd4;
   localparam logic [2:0] OP_BORDER = 3'd5;

   localparam logic [1:0] REGION_LEFT = 2'd0;
   localparam logic [1:0] REGION_GAME = 2'd1;
   localparam logic [1:0] REGION_RIGHT = 2'd2;
   localparam logic [1:0] REGION_BEYOND = 2'd3;

   localparam logic [1:0] CSR_GAME_WIDTH = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_WIDE_WIDTH = 2'd2;

   localparam logic [CFG_W-1:0] GAME_WIDTH_RST = 13'd768;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd576;
   localparam logic [CFG_W-1:0] WIDE_WIDTH_RST = 13'd1024;

   localparam logic [7:0] CHAN_MAX = 8'hFF;
   localparam logic [15:0] SUM_MAX = 16'hFFFF;
   // x/3 for x <= 255 as (x * 171) >> 9
   localparam logic [7:0] THIRD_MUL = 8'd171;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] entry_index;
      logic [5:0] entry_red;
      logic [5:0] entry_green;
      logic [5:0] entry_blue;
      logic [7:0] edge_index;
      logic [12:0] pixel_x;
      logic [11:0] pixel_y;
      logic [23:0] game_pixel;
   } req_type;

   typedef struct packed {
      logic [23:0] out_color;
      logic [1:0] region;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] game_width;
      logic [CFG_W-1:0] frame_height;
      logic [CFG_W-1:0] wide_width;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] idx;
      logic [23:0] color;
      logic [1:0] region;
      logic [11:0] num;
      logic [11:0] row;
   } entry_type;

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [11:0] border_width(input cfg_type c);
      logic [CFG_W-1:0] excess;
      excess = c.wide_width - c.game_width;
      return (c.wide_width > c.game_width) ? excess[CFG_W-1:1] : 12'd0;
   endfunction

   function automatic logic [CFG_W-1:0] row_den(input cfg_type c);
      return (c.frame_height >= 13'd2) ? c.frame_height - 13'd1 : 13'd0;
   endfunction

endpackage

// ===== hdl/widescreen_border_compositor.sv =====
// Channel  Ports                          Moves
// req      req_valid/req_ready/req_data   one input item (req_type)
// rsp      rsp_valid/rsp_ready/rsp_data   one result item (rsp_type)
// csr      csr_valid/csr_ready/csr_index  register write, csr_data
//
// Palette writes finish in the idle state; edge samples read the palette first;
// border pixels do a lerp division (skipped when the frame height is below
// two) and a fade division per channel on the shared one-bit-per-cycle
// divider. Latches do one reciprocal multiply per channel.
// Reset is synchronous; sums and border colors clear, the palette does not.
// A two-item queue and the output register let each side stall on its own.
module widescreen_border_compositor import wbc_pkg::*; #(
   parameter int SOURCE_WIDTH = 256,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic q_valid, q_pop;
   entry_type q_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAME_WIDTH: cfg_in.game_width = csr_data;
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_data;
            CSR_WIDE_WIDTH: cfg_in.wide_width = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.game_width <= GAME_WIDTH_RST;
         cfg_ff.frame_height <= FRAME_HEIGHT_RST;
         cfg_ff.wide_width <= WIDE_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   wbc_back #(
      .SOURCE_WIDTH    (SOURCE_WIDTH),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/wbc_ram.sv =====
module wbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/wbc_front.sv =====
module wbc_front import wbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      q_valid,
   output entry_type q_entry,
   input  logic      q_pop
);

   entry_type ent;
   logic keep;
   logic [11:0] bw;
   logic [CFG_W-1:0] den;
   logic [14:0] game_end, right_end, right_num;

   always_comb begin
      bw = border_width(cfg);
      den = row_den(cfg);
      game_end = 15'(bw) + 15'(cfg.game_width);
      right_end = game_end + 15'(bw);
      right_num = right_end - 15'd1 - 15'(req_data.pixel_x);
      ent = '0;
      ent.row = ({1'b0, req_data.pixel_y} > den) ? den[11:0] : req_data.pixel_y;
      keep = 1'b1;
      unique case (req_data.kind)
         KIND_PAL_WRITE: begin
            ent.op = OP_PAL_WRITE;
            ent.idx = req_data.entry_index;
            ent.color = {widen6(req_data.entry_red), widen6(req_data.entry_green),
                         widen6(req_data.entry_blue)};
         end
         KIND_TOP_SAMPLE: begin
            ent.op = OP_TOP_SAMPLE;
            ent.idx = req_data.edge_index;
         end
         KIND_BOT_SAMPLE: begin
            ent.op = OP_BOT_SAMPLE;
            ent.idx = req_data.edge_index;
         end
         KIND_LATCH: begin
            ent.op = OP_LATCH;
         end
         KIND_PIXEL: begin
            priority if (15'(req_data.pixel_x) < 15'(bw)) begin
               ent.op = OP_BORDER;
               ent.region = REGION_LEFT;
               ent.num = req_data.pixel_x[11:0];
            end else if (15'(req_data.pixel_x) < game_end) begin
               ent.op = OP_PASS;
               ent.region = REGION_GAME;
               ent.color = req_data.game_pixel;
            end else if (15'(req_data.pixel_x) < right_end) begin
               ent.op = OP_BORDER;
               ent.region = REGION_RIGHT;
               ent.num = right_num[11:0];
            end else begin
               ent.op = OP_PASS;
               ent.region = REGION_BEYOND;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // two-entry queue toward the back end
   entry_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready && keep;
   assign pop = q_pop && (count_ff != 2'd0);
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

// ===== hdl/wbc_div.sv =====
module wbc_div import wbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DSR_W:0] rem_sh, rem_sub;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = DIV_CNT_W'(DIV_W - 1);
         rem_in = '0;
         dsr_in = divisor;
         quo_in = dividend;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sub[DSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/wbc_back.sv =====
module wbc_back import wbc_pkg::*; #(
   parameter int SOURCE_WIDTH = 256,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   // sum / SOURCE_WIDTH as (sum * LAT_MUL) >> LAT_SH, exact for 16-bit sums
   localparam int LAT_SH = 16 + $clog2(SOURCE_WIDTH);
   localparam logic [32:0] LAT_MUL =
      33'(((64'd1 << LAT_SH) + 64'(SOURCE_WIDTH) - 64'd1) / 64'(SOURCE_WIDTH));

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ACC = 4'd1;
   localparam logic [3:0] S_LATCH = 4'd2;
   localparam logic [3:0] S_LERP_GO = 4'd4;
   localparam logic [3:0] S_LERP_WT = 4'd5;
   localparam logic [3:0] S_SCALE = 4'd6;
   localparam logic [3:0] S_FADE_GO = 4'd7;
   localparam logic [3:0] S_FADE_WT = 4'd8;
   localparam logic [3:0] S_OUT = 4'd9;

   function automatic logic [7:0] chan(input logic [23:0] c, input logic [2:0] k);
      logic [7:0] v;
      unique case (k)
         3'd0: v = c[23:16];
         3'd1: v = c[15:8];
         default: v = c[7:0];
      endcase
      return v;
   endfunction

   function automatic logic [15:0] add_sat(input logic [15:0] s, input logic [7:0] v);
      logic [16:0] t;
      t = 17'(s) + 17'(v);
      return t[16] ? SUM_MAX : t[15:0];
   endfunction

   logic [3:0] state_ff, state_in;
   entry_type cur_ff, cur_in;
   logic [2:0] k_ff, k_in;
   logic [15:0] top_sum_ff [3];
   logic [15:0] bot_sum_ff [3];
   logic [15:0] top_sum_in [3];
   logic [15:0] bot_sum_in [3];
   logic [23:0] top_color_ff, top_color_in, bot_color_ff, bot_color_in;
   logic [23:0] res_ff, res_in;
   logic [7:0] lerp_ff, lerp_in;
   logic [6:0] third_ff, third_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic ram_we;
   logic [23:0] ram_rdata, sample;
   logic div_start, div_done;
   logic [DIV_W-1:0] div_dvd, div_quo;
   logic [DSR_W-1:0] div_dsr;

   logic [11:0] bw;
   logic [CFG_W-1:0] den;
   logic [7:0] t_ch, b_ch, mag, lat_ch;
   logic neg;
   logic [15:0] lat_sum;
   logic [32:0] lat_prod, lat_quo;
   logic [15:0] third_prod;
   logic [7:0] q_lo;

   wbc_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_entry.idx[AW-1:0]),
      .wr_data (q_entry.color),
      .rd_addr (q_entry.idx[AW-1:0]),
      .rd_data (ram_rdata)
   );

   wbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign ram_we = (state_ff == S_IDLE) && q_valid && (q_entry.op == OP_PAL_WRITE) &&
                   (9'(q_entry.idx) < 9'(PALETTE_ENTRIES));

   always_comb begin
      bw = border_width(cfg);
      den = row_den(cfg);
      t_ch = chan(top_color_ff, k_ff);
      b_ch = chan(bot_color_ff, k_ff);
      neg = b_ch < t_ch;
      mag = neg ? t_ch - b_ch : b_ch - t_ch;
      q_lo = div_quo[7:0];
      third_prod = 16'(lerp_ff) * 16'(THIRD_MUL);
      sample = (9'(cur_ff.idx) < 9'(PALETTE_ENTRIES)) ? ram_rdata : 24'd0;
      unique case (k_ff)
         3'd0: lat_sum = top_sum_ff[0];
         3'd1: lat_sum = top_sum_ff[1];
         3'd2: lat_sum = top_sum_ff[2];
         3'd3: lat_sum = bot_sum_ff[0];
         3'd4: lat_sum = bot_sum_ff[1];
         default: lat_sum = bot_sum_ff[2];
      endcase
      lat_prod = 33'(lat_sum) * LAT_MUL;
      lat_quo = lat_prod >> LAT_SH;
      lat_ch = (lat_quo > 33'(CHAN_MAX)) ? CHAN_MAX : lat_quo[7:0];

      state_in = state_ff;
      cur_in = cur_ff;
      k_in = k_ff;
      top_sum_in = top_sum_ff;
      bot_sum_in = bot_sum_ff;
      top_color_in = top_color_ff;
      bot_color_in = bot_color_ff;
      res_in = res_ff;
      lerp_in = lerp_ff;
      third_in = third_ff;
      q_pop = 1'b0;
      div_start = 1'b0;
      div_dvd = '0;
      div_dsr = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_entry;
               k_in = 3'd0;
               res_in = q_entry.color;
               unique case (q_entry.op)
                  OP_TOP_SAMPLE, OP_BOT_SAMPLE: state_in = S_ACC;
                  OP_LATCH: state_in = S_LATCH;
                  OP_PASS: state_in = S_OUT;
                  OP_BORDER: state_in = S_LERP_GO;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ACC: begin
            for (int i = 0; i < 3; i++) begin
               if (cur_ff.op == OP_TOP_SAMPLE) begin
                  top_sum_in[i] = add_sat(top_sum_ff[i], chan(sample, 3'(i)));
               end else begin
                  bot_sum_in[i] = add_sat(bot_sum_ff[i], chan(sample, 3'(i)));
               end
            end
            state_in = S_IDLE;
         end
         S_LATCH: begin
            unique case (k_ff)
               3'd0: top_color_in[23:16] = lat_ch;
               3'd1: top_color_in[15:8] = lat_ch;
               3'd2: top_color_in[7:0] = lat_ch;
               3'd3: bot_color_in[23:16] = lat_ch;
               3'd4: bot_color_in[15:8] = lat_ch;
               default: bot_color_in[7:0] = lat_ch;
            endcase
            if (k_ff == 3'd5) begin
               for (int i = 0; i < 3; i++) begin
                  top_sum_in[i] = '0;
                  bot_sum_in[i] = '0;
               end
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_LERP_GO: begin
            if (den == '0) begin
               lerp_in = t_ch;
               state_in = S_SCALE;
            end else begin
               div_start = 1'b1;
               div_dvd = DIV_W'(mag) * DIV_W'(cur_ff.row);
               div_dsr = den;
               state_in = S_LERP_WT;
            end
         end
         S_LERP_WT: begin
            if (div_done) begin
               lerp_in = neg ? t_ch - q_lo : t_ch + q_lo;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            third_in = third_prod[15:9];
            state_in = S_FADE_GO;
         end
         S_FADE_GO: begin
            div_start = 1'b1;
            div_dvd = DIV_W'(third_ff) * DIV_W'(cur_ff.num);
            div_dsr = DSR_W'(bw);
            state_in = S_FADE_WT;
         end
         S_FADE_WT: begin
            if (div_done) begin
               unique case (k_ff)
                  3'd0: res_in[23:16] = q_lo;
                  3'd1: res_in[15:8] = q_lo;
                  default: res_in[7:0] = q_lo;
               endcase
               if (k_ff == 3'd2) begin
                  state_in = S_OUT;
               end else begin
                  k_in = k_ff + 3'd1;
                  state_in = S_LERP_GO;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_color = res_ff;
               rsp_data_in.region = cur_ff.region;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            top_sum_ff[i] <= '0;
            bot_sum_ff[i] <= '0;
         end
         top_color_ff <= '0;
         bot_color_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         top_sum_ff <= top_sum_in;
         bot_sum_ff <= bot_sum_in;
         top_color_ff <= top_color_in;
         bot_color_ff <= bot_color_in;
      end
      cur_ff <= cur_in;
      k_ff <= k_in;
      res_ff <= res_in;
      lerp_ff <= lerp_in;
      third_ff <= third_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== verif/tb_widescreen_border_compositor.sv =====
module tb_widescreen_border_compositor;
   import wbc_pkg::*;

   localparam int SRC_W = 256;
   localparam int IDLE_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 400;
   localparam int LONG_HOLD = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   widescreen_border_compositor uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow state of the compositor
   logic [23:0] pal_shadow [256];
   logic [15:0] top_sum [3];
   logic [15:0] bot_sum [3];
   logic [7:0] top_chan [3];
   logic [7:0] bot_chan [3];
   cfg_type cfg_shadow;

   rsp_type pixel_queue [$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_go = 0;

   typedef struct {
      req_type item;
      bit typed;
      rsp_type want;
   } row_type;
   row_type rows [$];

   function automatic bit compose(input req_type r, output rsp_type o);
      int gw, ww, fh, bw, den, x, y, num, t, b, c, d;
      logic [23:0] col;
      gw = int'(cfg_shadow.game_width);
      ww = int'(cfg_shadow.wide_width);
      fh = int'(cfg_shadow.frame_height);
      o = '0;
      case (r.kind)
         KIND_PAL_WRITE: begin
            pal_shadow[r.entry_index] = {r.entry_red, r.entry_red[5:4],
                                         r.entry_green, r.entry_green[5:4],
                                         r.entry_blue, r.entry_blue[5:4]};
            return 0;
         end
         KIND_TOP_SAMPLE, KIND_BOT_SAMPLE: begin
            col = pal_shadow[r.edge_index];
            for (int k = 0; k < 3; k++) begin
               c = int'(col[16-8*k +: 8]);
               if (r.kind == KIND_TOP_SAMPLE) begin
                  d = top_sum[k] + c;
                  top_sum[k] = (d > 16'hFFFF) ? 16'hFFFF : d[15:0];
               end else begin
                  d = bot_sum[k] + c;
                  bot_sum[k] = (d > 16'hFFFF) ? 16'hFFFF : d[15:0];
               end
            end
            return 0;
         end
         KIND_LATCH: begin
            for (int k = 0; k < 3; k++) begin
               d = top_sum[k] / SRC_W;
               top_chan[k] = (d > 255) ? 8'hFF : d[7:0];
               d = bot_sum[k] / SRC_W;
               bot_chan[k] = (d > 255) ? 8'hFF : d[7:0];
               top_sum[k] = '0;
               bot_sum[k] = '0;
            end
            return 0;
         end
         KIND_PIXEL: begin
            x = int'(r.pixel_x);
            y = int'(r.pixel_y);
            bw = (ww > gw) ? (ww - gw) / 2 : 0;
            den = (fh >= 2) ? fh - 1 : 0;
            if (x < bw) begin
               o.region = REGION_LEFT;
               num = x;
            end else if (x < bw + gw) begin
               o.region = REGION_GAME;
               o.out_color = r.game_pixel;
               return 1;
            end else if (x < 2 * bw + gw) begin
               o.region = REGION_RIGHT;
               num = bw - 1 - (x - bw - gw);
            end else begin
               o.region = REGION_BEYOND;
               return 1;
            end
            if (y > den) y = den;
            for (int k = 0; k < 3; k++) begin
               t = int'(top_chan[k]);
               b = int'(bot_chan[k]);
               c = (den == 0) ? t : t + ((b - t) * y) / den;
               c = c / 3;
               c = (c * num) / bw;
               o.out_color[16-8*k +: 8] = c[7:0];
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result color=%h region=%0d", $time,
                     rsp_data.out_color, rsp_data.region);
         end else begin
            want = pixel_queue.pop_front();
            if (want.out_color !== rsp_data.out_color) begin
               errors++;
               $display("%0t: out_color expected %h actual %h", $time,
                        want.out_color, rsp_data.out_color);
            end
            if (want.region !== rsp_data.region) begin
               errors++;
               $display("%0t: region expected %0d actual %0d", $time,
                        want.region, rsp_data.region);
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // receiver: rotating stall patterns plus one long hold-off
   always @(negedge clock) begin
      int rx_cnt;
      int hold_left;
      if (hold_go && hold_left == 0) begin
         hold_left = LONG_HOLD;
         hold_go = 0;
      end
      rx_cnt++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cnt / 300) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ((rx_cnt % 7) < 3);
         endcase
      end
   end

   int burst_left = 0;

   // entered and left just after a falling edge
   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      rsp_type o;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      if (compose(it, o)) pixel_queue.push_back(typed ? want : o);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAME_WIDTH: cfg_shadow.game_width = val;
         CSR_FRAME_HEIGHT: cfg_shadow.frame_height = val;
         default: cfg_shadow.wide_width = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic req_type rand_item(input logic [2:0] k);
      req_type r;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.kind = k;
      return r;
   endfunction

   task automatic add_row(input req_type it, input bit typed, input logic [23:0] col,
                          input logic [1:0] reg_id);
      row_type rw;
      rw.item = it;
      rw.typed = typed;
      rw.want.out_color = col;
      rw.want.region = reg_id;
      rows.push_back(rw);
   endtask

   task automatic add_pixel(input int x, input int y, input logic [23:0] gp,
                            input bit typed, input logic [23:0] col, input logic [1:0] rg);
      req_type r;
      r = rand_item(KIND_PIXEL);
      r.pixel_x = 13'(x);
      r.pixel_y = 12'(y);
      r.game_pixel = gp;
      add_row(r, typed, col, rg);
   endtask

   task automatic add_entry(input logic [7:0] idx, input logic [5:0] rd,
                            input logic [5:0] gn, input logic [5:0] bl);
      req_type r;
      r = rand_item(KIND_PAL_WRITE);
      r.entry_index = idx;
      r.entry_red = rd;
      r.entry_green = gn;
      r.entry_blue = bl;
      add_row(r, 0, '0, REGION_LEFT);
   endtask

   task automatic add_sample(input logic [2:0] k, input logic [7:0] idx);
      req_type r;
      r = rand_item(k);
      r.edge_index = idx;
      add_row(r, 0, '0, REGION_LEFT);
   endtask

   task automatic random_phase(input int n_items, input bit saturate);
      req_type r;
      int gw, bw, ww, n, sel;
      gw = int'(cfg_shadow.game_width);
      ww = int'(cfg_shadow.wide_width);
      bw = (ww > gw) ? (ww - gw) / 2 : 0;
      if (saturate) begin
         r = rand_item(KIND_PAL_WRITE);
         r.entry_index = 8'd255;
         {r.entry_red, r.entry_green, r.entry_blue} = '1;
         send_item(r, 0, '0);
         for (int i = 0; i < 540; i++) begin
            r = rand_item(i < 270 ? KIND_TOP_SAMPLE : KIND_BOT_SAMPLE);
            r.edge_index = (i % 3 == 0) ? 8'($urandom_range(0, 255)) : 8'd255;
            send_item(r, 0, '0);
         end
      end
      n = 0;
      while (n < n_items) begin
         // one frame: edge rows, a latch most of the time, then a run of pixels
         repeat ($urandom_range(0, 12)) begin
            r = rand_item($urandom_range(0, 1) ? KIND_TOP_SAMPLE : KIND_BOT_SAMPLE);
            send_item(r, 0, '0);
            n++;
         end
         if ($urandom_range(0, 7) != 0) begin
            send_item(rand_item(KIND_LATCH), 0, '0);
            n++;
         end
         repeat ($urandom_range(4, 20)) begin
            r = rand_item(KIND_PIXEL);
            sel = $urandom_range(0, 5);
            if (sel == 0 && bw > 0) r.pixel_x = 13'($urandom_range(0, bw - 1));
            else if (sel == 1 && bw > 0) r.pixel_x = 13'(bw - 1 - $urandom_range(0, 2));
            else if (sel == 2 && bw > 0 && 2 * bw + gw <= 8191)
               r.pixel_x = 13'(bw + gw + $urandom_range(0, bw - 1));
            else if (sel == 3 && gw > 0 && bw + gw <= 8191)
               r.pixel_x = 13'(bw + $urandom_range(0, gw - 1));
            if ($urandom_range(0, 3) != 0)
               r.pixel_y = 12'($urandom_range(0, cfg_shadow.frame_height));
            send_item(r, 0, '0);
            n++;
         end
         // noise: palette rewrites and unused kinds
         if ($urandom_range(0, 3) == 0) begin
            send_item(rand_item(KIND_PAL_WRITE), 0, '0);
            n++;
         end
         if ($urandom_range(0, 9) == 0) send_item(rand_item(3'($urandom_range(5, 7))), 0, '0);
      end
   endtask

   task automatic set_config(input int gw, input int fh, input int ww);
      drain();
      write_reg(CSR_GAME_WIDTH, CFG_W'(gw));
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(fh));
      write_reg(CSR_WIDE_WIDTH, CFG_W'(ww));
   endtask

   initial begin
      row_type rw;
      for (int k = 0; k < 3; k++) begin
         top_sum[k] = '0; bot_sum[k] = '0; top_chan[k] = '0; bot_chan[k] = '0;
      end
      for (int i = 0; i < 256; i++) pal_shadow[i] = '0;
      cfg_shadow.game_width = GAME_WIDTH_RST;
      cfg_shadow.frame_height = FRAME_HEIGHT_RST;
      cfg_shadow.wide_width = WIDE_WIDTH_RST;

      // default frame: border 128 wide each side; border colors zero after reset
      add_pixel(0, 0, 24'h123456, 1, 24'h000000, REGION_LEFT);
      add_pixel(128, 4095, 24'hFFFFFF, 1, 24'hFFFFFF, REGION_GAME);
      add_pixel(895, 0, 24'h000000, 1, 24'h000000, REGION_GAME);
      add_pixel(1023, 100, 24'hABCDEF, 1, 24'h000000, REGION_RIGHT);
      add_pixel(8191, 4095, 24'hFFFFFF, 1, 24'h000000, REGION_BEYOND);
      add_entry(8'd0, 6'd0, 6'd0, 6'd0);
      add_entry(8'd255, 6'd63, 6'd63, 6'd63);
      add_entry(8'd17, 6'd63, 6'd0, 6'd21);
      add_entry(8'd200, 6'd1, 6'd62, 6'd32);
      add_sample(KIND_TOP_SAMPLE, 8'd255);
      add_sample(KIND_TOP_SAMPLE, 8'd255);
      add_sample(KIND_TOP_SAMPLE, 8'd0);
      add_sample(KIND_BOT_SAMPLE, 8'd17);
      add_sample(KIND_BOT_SAMPLE, 8'd200);
      add_row(rand_item(3'd5), 0, '0, REGION_LEFT);
      add_row(rand_item(3'd6), 0, '0, REGION_LEFT);
      add_row(rand_item(3'd7), 0, '0, REGION_LEFT);
      add_row(rand_item(KIND_LATCH), 0, '0, REGION_LEFT);
      add_pixel(127, 0, 24'h0, 0, '0, REGION_LEFT);
      add_pixel(64, 575, 24'h0, 0, '0, REGION_LEFT);
      add_pixel(100, 4095, 24'h0, 0, '0, REGION_LEFT);
      add_pixel(896, 300, 24'h0, 0, '0, REGION_RIGHT);
      add_pixel(1024, 0, 24'h0, 1, 24'h000000, REGION_BEYOND);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) begin
         rw = rows[i];
         send_item(rw.item, rw.typed, rw.want);
      end

      // fill the whole palette so every edge index reads a written entry
      for (int i = 0; i < 256; i++) begin
         req_type r;
         r = rand_item(KIND_PAL_WRITE);
         r.entry_index = 8'(i);
         send_item(r, 0, '0);
      end

      random_phase(100, 1);
      hold_go = 1;
      random_phase(100, 0);
      set_config(1, 2, 8191);
      random_phase(100, 0);
      set_config(4096, 4096, 1);
      random_phase(60, 0);
      set_config(100, 1, 301);
      random_phase(100, 0);
      set_config(0, 0, 50);
      random_phase(80, 0);
      set_config(200, 3000, 8191);
      random_phase(100, 0);
      set_config(4096, 4096, 8191);
      random_phase(100, 0);
      set_config(8191, 7, 8191);
      random_phase(60, 0);
      set_config(333, 96, 640);
      random_phase(150, 0);

      drain();
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
